[rtl/kcl_pkg.sv]
package kcl_pkg;

  // Code length and factory settings
  localparam int          CODE_DIGITS       = 4;
  localparam logic [15:0] DEFAULT_CODE_RST  = 16'h1234;
  localparam logic [3:0]  FAIL_LIMIT_RST    = 4'd3;
  localparam logic [7:0]  OPEN_SECONDS_RST  = 8'd5;
  localparam logic [7:0]  ALARM_SECONDS_RST = 8'd60;

  // Configuration register indexes
  localparam int         CFG_IDX_W         = 2;
  localparam logic [1:0] CFG_DEFAULT_CODE  = 2'd0;
  localparam logic [1:0] CFG_FAIL_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_OPEN_SECONDS  = 2'd2;
  localparam logic [1:0] CFG_ALARM_SECONDS = 2'd3;

  // Item kinds
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Matrix key positions
  localparam logic [4:0] KEY_D1      = 5'd1;
  localparam logic [4:0] KEY_D2      = 5'd2;
  localparam logic [4:0] KEY_D3      = 5'd3;
  localparam logic [4:0] KEY_SET     = 5'd4;
  localparam logic [4:0] KEY_D4      = 5'd5;
  localparam logic [4:0] KEY_D5      = 5'd6;
  localparam logic [4:0] KEY_D6      = 5'd7;
  localparam logic [4:0] KEY_RESTORE = 5'd8;
  localparam logic [4:0] KEY_D7      = 5'd9;
  localparam logic [4:0] KEY_D8      = 5'd10;
  localparam logic [4:0] KEY_D9      = 5'd11;
  localparam logic [4:0] KEY_CLEAR   = 5'd12;
  localparam logic [4:0] KEY_BACK    = 5'd13;
  localparam logic [4:0] KEY_D0      = 5'd14;
  localparam logic [4:0] KEY_ENTER   = 5'd15;
  localparam logic [4:0] KEY_OK      = 5'd16;

  // Display status codes
  localparam logic [1:0] DISP_DIGITS = 2'd0;
  localparam logic [1:0] DISP_ERR    = 2'd1;
  localparam logic [1:0] DISP_ON     = 2'd2;

  localparam logic [3:0] FAIL_MAX = 4'd15;
  localparam logic [7:0] SEC_MAX  = 8'd255;

endpackage

[rtl/keypad_code_lock_controller_top.sv]
// Keypad code lock controller.
// Input channel (in_valid / in_stall): one beat is either a key press
// (in_func = 0, in_key_code = matrix position 1..16) or a one-second tick
// (in_func = 1). Result channel (out_valid / out_stall): exactly one beat
// per input beat, carrying lock drive, alarm, programming-mode LED,
// display status, digit count and the entered digits as BCD.
// Config port (cfg_valid / cfg_ready, always ready): index 0 default code,
// 1 failure limit, 2 open seconds, 3 alarm seconds. Write only while idle.
// The result of a beat is registered and appears in the cycle after it is accepted.
// Throughput: one beat per cycle unless the receiver stalls; the whole update
// of lock state for a beat is one pass of decode/compare logic into the state
// and result registers. When the receiver stalls, the result register holds
// its beat; in_stall is raised only while that held beat blocks the next one,
// so a new beat is still taken in the cycle the held one leaves.
// Reset (rst_n low, synchronous): config returns to factory values, the
// stored code reloads from the factory code, all lock state clears and no
// result is pending.
module keypad_code_lock_controller_top #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [4:0]                   in_key_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_lock_open,
  output logic                         out_alarm_on,
  output logic                         out_set_mode_led,
  output logic [1:0]                   out_display_status,
  output logic [2:0]                   out_entry_count,
  output logic [15:0]                  out_entered_code,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);

  // Count must hold CODE_DIGITS itself
  localparam int CW    = $clog2(CODE_DIGITS + 1);
  // Digits that reach the 16-bit BCD fields
  localparam int SHOWN = (CODE_DIGITS < 4) ? CODE_DIGITS : 4;

  // Configuration registers
  logic [15:0] default_code_r;
  logic [3:0]  fail_limit_r;
  logic [7:0]  open_seconds_r;
  logic [7:0]  alarm_seconds_r;

  // Lock state
  logic [3:0]    digits_r [CODE_DIGITS];
  logic [3:0]    digits_nxt [CODE_DIGITS];
  logic [3:0]    stored_r [CODE_DIGITS];
  logic [3:0]    stored_nxt [CODE_DIGITS];
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    fail_r, fail_nxt;
  logic          prog_r, prog_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          lock_r, lock_nxt;
  logic          cd_active_r, cd_active_nxt;
  logic [7:0]    cd_sec_r, cd_sec_nxt;
  logic [7:0]    alarm_el_r, alarm_el_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_lock_open_r;
  logic        out_alarm_on_r;
  logic        out_set_mode_led_r;
  logic [1:0]  out_display_status_r;
  logic [2:0]  out_entry_count_r;
  logic [15:0] out_entered_code_r;

  logic        in_fire;
  logic        locked;
  logic        digit_hit;
  logic [3:0]  digit_val;
  logic        match;
  logic        locked_nxt;
  logic [15:0] code_nxt;

  // Take a new beat whenever the result register is empty or draining
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign locked = (fail_limit_r != 4'd0) && (fail_r >= fail_limit_r);

  // Digit keys on the matrix
  always_comb begin
    digit_hit = 1'b1;
    digit_val = 4'd0;
    unique case (in_key_code)
      kcl_pkg::KEY_D1: digit_val = 4'd1;
      kcl_pkg::KEY_D2: digit_val = 4'd2;
      kcl_pkg::KEY_D3: digit_val = 4'd3;
      kcl_pkg::KEY_D4: digit_val = 4'd4;
      kcl_pkg::KEY_D5: digit_val = 4'd5;
      kcl_pkg::KEY_D6: digit_val = 4'd6;
      kcl_pkg::KEY_D7: digit_val = 4'd7;
      kcl_pkg::KEY_D8: digit_val = 4'd8;
      kcl_pkg::KEY_D9: digit_val = 4'd9;
      kcl_pkg::KEY_D0: digit_val = 4'd0;
      default:         digit_hit = 1'b0;
    endcase
  end

  // Full entry equal to the stored code
  always_comb begin
    match = (count_r == CW'(CODE_DIGITS));
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (digits_r[i] != stored_r[i]) match = 1'b0;
    end
  end

  // Next lock state for the current beat
  always_comb begin
    digits_nxt    = digits_r;
    stored_nxt    = stored_r;
    count_nxt     = count_r;
    fail_nxt      = fail_r;
    prog_nxt      = prog_r;
    status_nxt    = status_r;
    lock_nxt      = lock_r;
    cd_active_nxt = cd_active_r;
    cd_sec_nxt    = cd_sec_r;
    alarm_el_nxt  = alarm_el_r;

    if (in_func == kcl_pkg::FUNC_TICK) begin
      if (cd_active_r && cd_sec_r != kcl_pkg::SEC_MAX) cd_sec_nxt = cd_sec_r + 8'd1;
      if (locked) begin
        if (alarm_el_r != kcl_pkg::SEC_MAX) alarm_el_nxt = alarm_el_r + 8'd1;
        if (alarm_el_nxt > alarm_seconds_r) begin
          fail_nxt     = 4'd0;
          alarm_el_nxt = 8'd0;
        end
      end
      // Countdown expired: drop back to the idle display
      if (cd_active_r && cd_sec_nxt >= open_seconds_r) begin
        status_nxt    = kcl_pkg::DISP_DIGITS;
        cd_active_nxt = 1'b0;
        prog_nxt      = 1'b0;
        lock_nxt      = 1'b0;
        cd_sec_nxt    = 8'd0;
        alarm_el_nxt  = 8'd0;
        count_nxt     = '0;
        for (int i = 0; i < CODE_DIGITS; i++) digits_nxt[i] = 4'd0;
      end
    end else if (!locked) begin
      if (digit_hit) begin
        if (count_r < CW'(CODE_DIGITS)) begin
          for (int i = 0; i < CODE_DIGITS; i++) begin
            if (count_r == CW'(i)) digits_nxt[i] = digit_val;
          end
          count_nxt = count_r + CW'(1);
        end
      end else begin
        priority case (in_key_code)
          kcl_pkg::KEY_CLEAR, kcl_pkg::KEY_SET: begin
            status_nxt    = kcl_pkg::DISP_DIGITS;
            cd_active_nxt = 1'b0;
            lock_nxt      = 1'b0;
            cd_sec_nxt    = 8'd0;
            alarm_el_nxt  = 8'd0;
            count_nxt     = '0;
            for (int i = 0; i < CODE_DIGITS; i++) digits_nxt[i] = 4'd0;
            if (in_key_code == kcl_pkg::KEY_CLEAR) begin
              fail_nxt = 4'd0;
              prog_nxt = 1'b0;
            end else begin
              prog_nxt = !prog_r;
            end
          end
          kcl_pkg::KEY_BACK: begin
            if (count_r != '0) count_nxt = count_r - CW'(1);
          end
          kcl_pkg::KEY_ENTER: begin
            if (!prog_r) begin
              count_nxt = '0;
              if (match) begin
                lock_nxt   = 1'b1;
                status_nxt = kcl_pkg::DISP_ON;
              end else begin
                if (fail_r != kcl_pkg::FAIL_MAX) fail_nxt = fail_r + 4'd1;
                status_nxt = kcl_pkg::DISP_ERR;
              end
              cd_active_nxt = 1'b1;
            end
          end
          kcl_pkg::KEY_OK: begin
            if (prog_r) begin
              if (count_r == CW'(CODE_DIGITS)) begin
                stored_nxt = digits_r;
                status_nxt = kcl_pkg::DISP_DIGITS;
              end else begin
                status_nxt = kcl_pkg::DISP_ERR;
              end
              prog_nxt  = 1'b0;
              count_nxt = '0;
              for (int i = 0; i < CODE_DIGITS; i++) digits_nxt[i] = 4'd0;
            end
          end
          kcl_pkg::KEY_RESTORE: begin
            for (int i = 0; i < CODE_DIGITS; i++) stored_nxt[i] = 4'd0;
            for (int i = 0; i < SHOWN; i++) begin
              stored_nxt[i] = default_code_r[4*(3-i) +: 4];
            end
          end
          default: begin
            // unused key position: hold everything
          end
        endcase
      end
    end
  end

  // Result fields from the updated state
  always_comb begin
    locked_nxt = (fail_limit_r != 4'd0) && (fail_nxt >= fail_limit_r);
    code_nxt   = 16'd0;
    for (int i = 0; i < SHOWN; i++) begin
      if (count_nxt > CW'(i)) code_nxt[4*(3-i) +: 4] = digits_nxt[i];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_code_r  <= kcl_pkg::DEFAULT_CODE_RST;
      fail_limit_r    <= kcl_pkg::FAIL_LIMIT_RST;
      open_seconds_r  <= kcl_pkg::OPEN_SECONDS_RST;
      alarm_seconds_r <= kcl_pkg::ALARM_SECONDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kcl_pkg::CFG_DEFAULT_CODE:  default_code_r  <= cfg_data;
        kcl_pkg::CFG_FAIL_LIMIT:    fail_limit_r    <= cfg_data[3:0];
        kcl_pkg::CFG_OPEN_SECONDS:  open_seconds_r  <= cfg_data[7:0];
        kcl_pkg::CFG_ALARM_SECONDS: alarm_seconds_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Lock state: advance once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits_r[i] <= 4'd0;
      end
      for (int i = 0; i < SHOWN; i++) begin
        stored_r[i] <= kcl_pkg::DEFAULT_CODE_RST[4*(3-i) +: 4];
      end
      for (int i = SHOWN; i < CODE_DIGITS; i++) begin
        stored_r[i] <= 4'd0;
      end
      count_r     <= '0;
      fail_r      <= 4'd0;
      prog_r      <= 1'b0;
      status_r    <= kcl_pkg::DISP_DIGITS;
      lock_r      <= 1'b0;
      cd_active_r <= 1'b0;
      cd_sec_r    <= 8'd0;
      alarm_el_r  <= 8'd0;
    end else if (in_fire) begin
      digits_r    <= digits_nxt;
      stored_r    <= stored_nxt;
      count_r     <= count_nxt;
      fail_r      <= fail_nxt;
      prog_r      <= prog_nxt;
      status_r    <= status_nxt;
      lock_r      <= lock_nxt;
      cd_active_r <= cd_active_nxt;
      cd_sec_r    <= cd_sec_nxt;
      alarm_el_r  <= alarm_el_nxt;
    end
  end

  // Result valid: set on accept, drop when taken with nothing new behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_lock_open_r      <= lock_nxt;
      out_alarm_on_r       <= locked_nxt;
      out_set_mode_led_r   <= prog_nxt;
      out_display_status_r <= status_nxt;
      out_entry_count_r    <= 3'(count_nxt);
      out_entered_code_r   <= code_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lock_open      = out_lock_open_r;
  assign out_alarm_on       = out_alarm_on_r;
  assign out_set_mode_led   = out_set_mode_led_r;
  assign out_display_status = out_display_status_r;
  assign out_entry_count    = out_entry_count_r;
  assign out_entered_code   = out_entered_code_r;

`ifndef SYNTHESIS
  // Input blocked only behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending result");

  // Every accepted beat yields a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

  // Entry never grows past the code length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CODE_DIGITS))
    else $error("digit count beyond code length");

  // Programming mode and an open lock exclude each other
  a_prog_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r |-> !lock_r)
    else $error("lock open in programming mode");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  // Unused key positions at both ends of the 5-bit code
  localparam logic [4:0] KEY_NONE = 5'd0;
  localparam logic [4:0] KEY_TOP  = 5'd31;

  localparam int HOLD_CYCLES  = 48;
  localparam int CHUNK_BEATS  = 60;
  localparam int CHUNKS       = 8;
  localparam int PRINT_LIMIT  = 40;

  // One result beat as the lock shows it
  typedef struct packed {
    logic        lock_open;
    logic        alarm_on;
    logic        set_mode;
    logic [1:0]  disp;
    logic [2:0]  count;
    logic [15:0] code;
  } lock_view_t;

  typedef struct packed {
    logic       func;
    logic [4:0] key;
    logic       typed;
    lock_view_t want;
  } script_row_t;

  // Views that can be read straight off the key sequence
  localparam lock_view_t V_IDLE = '0;
  localparam lock_view_t V_ONE  =
    '{1'b0, 1'b0, 1'b0, kcl_pkg::DISP_DIGITS, 3'd1, 16'h1000};
  localparam lock_view_t V_PROG =
    '{1'b0, 1'b0, 1'b1, kcl_pkg::DISP_DIGITS, 3'd0, 16'h0000};
  localparam lock_view_t V_ERR  =
    '{1'b0, 1'b0, 1'b0, kcl_pkg::DISP_ERR, 3'd0, 16'h0000};
  localparam lock_view_t V_OPEN =
    '{1'b1, 1'b0, 1'b0, kcl_pkg::DISP_ON, 3'd0, 16'h0000};

  // Directed opening: stray codes, program mode corner cases, restore, clear, open
  localparam script_row_t OPENING [26] = '{
    '{kcl_pkg::FUNC_TICK, KEY_TOP,              1'b1, V_IDLE},  // tick ignores its key field
    '{kcl_pkg::FUNC_KEY,  KEY_NONE,             1'b1, V_IDLE},  // no key
    '{kcl_pkg::FUNC_KEY,  KEY_TOP,              1'b1, V_IDLE},  // unused position
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_OK,      1'b1, V_IDLE},  // OK outside program mode
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D1,      1'b1, V_ONE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_BACK,    1'b1, V_IDLE},  // dropped digit reads as zero
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_SET,     1'b1, V_PROG},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_ENTER,   1'b1, V_PROG},  // enter ignored while programming
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D9,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_OK,      1'b1, V_ERR},   // short code rejected
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_SET,     1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D0,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D9,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D0,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D9,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D8,      1'b0, V_IDLE},  // fifth digit dropped
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_OK,      1'b1, V_IDLE},  // new code stored
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_ENTER,   1'b1, V_ERR},   // empty entry fails
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_RESTORE, 1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_CLEAR,   1'b1, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D1,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D2,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D3,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_D4,      1'b0, V_IDLE},
    '{kcl_pkg::FUNC_KEY,  kcl_pkg::KEY_ENTER,   1'b1, V_OPEN},  // factory code opens
    '{kcl_pkg::FUNC_TICK, KEY_NONE,             1'b0, V_IDLE}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = kcl_pkg::FUNC_KEY;
  logic [4:0]  in_key_code = KEY_NONE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_lock_open;
  logic        out_alarm_on;
  logic        out_set_mode_led;
  logic [1:0]  out_display_status;
  logic [2:0]  out_entry_count;
  logic [15:0] out_entered_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index = kcl_pkg::CFG_DEFAULT_CODE;
  logic [15:0] cfg_data = 16'h0000;

  keypad_code_lock_controller_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_lock_open      (out_lock_open),
    .out_alarm_on       (out_alarm_on),
    .out_set_mode_led   (out_set_mode_led),
    .out_display_status (out_display_status),
    .out_entry_count    (out_entry_count),
    .out_entered_code   (out_entered_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lock state mirror, kept in step with every accepted input beat
  logic [15:0] cfg_default;
  logic [3:0]  cfg_fail_limit;
  logic [7:0]  cfg_open;
  logic [7:0]  cfg_alarm;
  logic [3:0]  ent_dig [kcl_pkg::CODE_DIGITS];
  logic [3:0]  code_dig [kcl_pkg::CODE_DIGITS];
  logic [2:0]  ent_cnt;
  logic [3:0]  fails;
  logic        prog;
  logic [1:0]  shown;
  logic        lock_q;
  logic        cd_on;
  logic [7:0]  cd_sec;
  logic [7:0]  alarm_cnt;

  lock_view_t  lock_views_due[$];

  int err_count = 0;
  int beats_in = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int lockouts_seen = 0;
  int opens_seen = 0;
  int held_in_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  function automatic logic keypad_locked();
    return cfg_fail_limit != 0 && fails >= cfg_fail_limit;
  endfunction

  function automatic void clear_entry();
    foreach (ent_dig[i]) ent_dig[i] = 4'd0;
    ent_cnt = 3'd0;
  endfunction

  function automatic void clear_lock_state();
    shown = kcl_pkg::DISP_DIGITS;
    cd_on = 1'b0;
    prog = 1'b0;
    lock_q = 1'b0;
    cd_sec = 8'd0;
    alarm_cnt = 8'd0;
    clear_entry();
  endfunction

  function automatic void reload_code();
    foreach (code_dig[i]) code_dig[i] = (i < 4) ? cfg_default[15 - 4 * i -: 4] : 4'd0;
  endfunction

  function automatic int digit_of_key(logic [4:0] key);
    case (key)
      kcl_pkg::KEY_D1: return 1;
      kcl_pkg::KEY_D2: return 2;
      kcl_pkg::KEY_D3: return 3;
      kcl_pkg::KEY_D4: return 4;
      kcl_pkg::KEY_D5: return 5;
      kcl_pkg::KEY_D6: return 6;
      kcl_pkg::KEY_D7: return 7;
      kcl_pkg::KEY_D8: return 8;
      kcl_pkg::KEY_D9: return 9;
      kcl_pkg::KEY_D0: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [4:0] key_for_digit(logic [3:0] d);
    case (d)
      4'd1: return kcl_pkg::KEY_D1;
      4'd2: return kcl_pkg::KEY_D2;
      4'd3: return kcl_pkg::KEY_D3;
      4'd4: return kcl_pkg::KEY_D4;
      4'd5: return kcl_pkg::KEY_D5;
      4'd6: return kcl_pkg::KEY_D6;
      4'd7: return kcl_pkg::KEY_D7;
      4'd8: return kcl_pkg::KEY_D8;
      4'd9: return kcl_pkg::KEY_D9;
      default: return kcl_pkg::KEY_D0;
    endcase
  endfunction

  function automatic void reset_lock_model();
    cfg_default = kcl_pkg::DEFAULT_CODE_RST;
    cfg_fail_limit = kcl_pkg::FAIL_LIMIT_RST;
    cfg_open = kcl_pkg::OPEN_SECONDS_RST;
    cfg_alarm = kcl_pkg::ALARM_SECONDS_RST;
    clear_lock_state();
    fails = 4'd0;
    reload_code();
  endfunction

  function automatic void press_key(logic [4:0] key);
    int d;
    logic match;
    logic was;
    d = digit_of_key(key);
    if (keypad_locked()) return;
    if (d >= 0) begin
      if (ent_cnt < kcl_pkg::CODE_DIGITS) begin
        ent_dig[ent_cnt] = 4'(d);
        ent_cnt++;
      end
      return;
    end
    case (key)
      kcl_pkg::KEY_CLEAR: begin
        clear_lock_state();
        fails = 4'd0;
      end
      kcl_pkg::KEY_BACK: begin
        if (ent_cnt > 0) ent_cnt--;
      end
      kcl_pkg::KEY_ENTER: begin
        if (!prog) begin
          match = (ent_cnt == kcl_pkg::CODE_DIGITS);
          foreach (ent_dig[i]) if (ent_dig[i] != code_dig[i]) match = 1'b0;
          ent_cnt = 3'd0;
          if (match) begin
            lock_q = 1'b1;
            shown = kcl_pkg::DISP_ON;
          end else begin
            if (fails < kcl_pkg::FAIL_MAX) fails++;
            shown = kcl_pkg::DISP_ERR;
          end
          cd_on = 1'b1;
        end
      end
      kcl_pkg::KEY_SET: begin
        was = prog;
        clear_lock_state();
        prog = !was;
      end
      kcl_pkg::KEY_OK: begin
        if (prog) begin
          if (ent_cnt == kcl_pkg::CODE_DIGITS) begin
            foreach (code_dig[i]) code_dig[i] = ent_dig[i];
            shown = kcl_pkg::DISP_DIGITS;
          end else begin
            shown = kcl_pkg::DISP_ERR;
          end
          prog = 1'b0;
          clear_entry();
        end
      end
      kcl_pkg::KEY_RESTORE: reload_code();
      default: ;
    endcase
  endfunction

  function automatic void second_tick();
    if (cd_on && cd_sec < kcl_pkg::SEC_MAX) cd_sec++;
    if (keypad_locked()) begin
      if (alarm_cnt < kcl_pkg::SEC_MAX) alarm_cnt++;
      if (alarm_cnt > cfg_alarm) begin
        fails = 4'd0;
        alarm_cnt = 8'd0;
      end
    end
    if (cd_on && cd_sec >= cfg_open) clear_lock_state();
  endfunction

  // Apply one beat to the mirror and return what the lock must show after it
  function automatic lock_view_t advance_lock(logic func, logic [4:0] key);
    lock_view_t v;
    if (func == kcl_pkg::FUNC_TICK) second_tick();
    else press_key(key);
    v = '0;
    for (int i = 0; i < 4; i++) if (i < ent_cnt) v.code[15 - 4 * i -: 4] = ent_dig[i];
    v.lock_open = lock_q;
    v.alarm_on = keypad_locked();
    v.set_mode = prog;
    v.disp = shown;
    v.count = ent_cnt;
    return v;
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    if (err_count < PRINT_LIMIT)
      $display("MISMATCH %s at %0t: got %0h, want %0h", field, $time, got, want);
    err_count++;
  endtask

  // Offer one beat, hold it until taken, then log the view it must produce.
  // A typed view, when given, stands in for the mirror's own answer.
  task automatic send_beat(logic func, logic [4:0] key, logic typed, lock_view_t want);
    lock_view_t v;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_key_code <= key;
    do @(posedge clk); while (in_stall);
    v = advance_lock(func, key);
    if (v.alarm_on) lockouts_seen++;
    if (v.lock_open) opens_seen++;
    lock_views_due.push_back(typed ? want : v);
    beats_in++;
  endtask

  task automatic send_key(logic [4:0] key);
    send_beat(kcl_pkg::FUNC_KEY, key, 1'b0, V_IDLE);
  endtask

  task automatic send_tick();
    send_beat(kcl_pkg::FUNC_TICK, 5'($urandom_range(31)), 1'b0, V_IDLE);
  endtask

  // Drop valid and wait until every view logged so far has come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (lock_views_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Hold cfg_valid high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [kcl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      kcl_pkg::CFG_DEFAULT_CODE:  cfg_default = val;
      kcl_pkg::CFG_FAIL_LIMIT:    cfg_fail_limit = val[3:0];
      kcl_pkg::CFG_OPEN_SECONDS:  cfg_open = val[7:0];
      kcl_pkg::CFG_ALARM_SECONDS: cfg_alarm = val[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // One user action: mostly realistic key sequences, some ticks and noise
  task automatic run_sequence();
    int pick;
    int n;
    int span;
    logic [3:0] d;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // the right code: leave program mode, wipe leftovers, type and enter
      if (prog) send_key(kcl_pkg::KEY_SET);
      n = ent_cnt;
      repeat (n) send_key(kcl_pkg::KEY_BACK);
      for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
        d = code_dig[i];
        if (d > 9) d = 4'($urandom_range(9));
        send_key(key_for_digit(d));
      end
      if ($urandom_range(9) == 0) send_key(key_for_digit(4'($urandom_range(9))));
      send_key(kcl_pkg::KEY_ENTER);
    end else if (pick < 48) begin
      // a guess, possibly short or corrected on the way
      n = $urandom_range(0, 5);
      repeat (n) begin
        send_key(key_for_digit(4'($urandom_range(9))));
        if ($urandom_range(6) == 0) send_key(kcl_pkg::KEY_BACK);
      end
      send_key(kcl_pkg::KEY_ENTER);
    end else if (pick < 60) begin
      // program a new code, now and then a short one
      if (!prog) send_key(kcl_pkg::KEY_SET);
      n = ($urandom_range(9) < 8) ? kcl_pkg::CODE_DIGITS : $urandom_range(0, 3);
      repeat (n) send_key(key_for_digit(4'($urandom_range(9))));
      if ($urandom_range(9) == 0) send_key(kcl_pkg::KEY_SET);
      else send_key(kcl_pkg::KEY_OK);
    end else if (pick < 75) begin
      // let time pass toward the close or alarm deadline
      span = keypad_locked() ? cfg_alarm + 2 : cfg_open + 1;
      if (span > 40) span = 40;
      n = $urandom_range(1, span);
      repeat (n) send_tick();
    end else if (pick < 85) begin
      send_beat(1'($urandom_range(1)), 5'($urandom_range(31)), 1'b0, V_IDLE);
    end else if (pick < 92) begin
      send_key(($urandom_range(1) == 0) ? kcl_pkg::KEY_CLEAR : kcl_pkg::KEY_SET);
    end else begin
      send_key(kcl_pkg::KEY_RESTORE);
    end
  endtask

  function automatic logic [15:0] random_bcd();
    logic [15:0] v;
    for (int i = 0; i < 4; i++) v[4 * i +: 4] = 4'($urandom_range(9));
    return v;
  endfunction

  // Receiver: random stall, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_left == 0 && hold_taken < hold_asked) begin
      hold_left = HOLD_CYCLES;
      hold_taken++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) held_in_cycles++;
  end

  // Check each taken result beat against the oldest logged view
  always @(posedge clk) begin : result_check
    lock_view_t got;
    lock_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_lock_open, out_alarm_on, out_set_mode_led, out_display_status,
              out_entry_count, out_entered_code};
      if (lock_views_due.size() == 0) begin
        note_mismatch("beat with nothing expected", got.code, 0);
      end else begin
        want = lock_views_due.pop_front();
        if (got.lock_open !== want.lock_open) note_mismatch("lock_open", got.lock_open,
                                                            want.lock_open);
        if (got.alarm_on !== want.alarm_on) note_mismatch("alarm_on", got.alarm_on,
                                                          want.alarm_on);
        if (got.set_mode !== want.set_mode) note_mismatch("set_mode_led", got.set_mode,
                                                          want.set_mode);
        if (got.disp !== want.disp) note_mismatch("display_status", got.disp, want.disp);
        if (got.count !== want.count) note_mismatch("entry_count", got.count, want.count);
        if (got.code !== want.code) note_mismatch("entered_code", got.code, want.code);
        beats_checked++;
      end
    end
  end

  initial begin
    int chunk_start;
    reset_lock_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed opening at factory settings with no idling
    foreach (OPENING[i]) send_beat(OPENING[i].func, OPENING[i].key, OPENING[i].typed,
                                   OPENING[i].want);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      // Reprogram only once the pipe is empty
      if (chunk > 0) begin
        settle_idle();
        case (chunk)
          1: begin  // low extremes, top factory code
            write_reg(kcl_pkg::CFG_DEFAULT_CODE, 16'h9999);
            write_reg(kcl_pkg::CFG_FAIL_LIMIT, 16'd1);
            write_reg(kcl_pkg::CFG_OPEN_SECONDS, 16'd1);
            write_reg(kcl_pkg::CFG_ALARM_SECONDS, 16'd1);
          end
          2: begin  // high extremes, all-zero factory code
            write_reg(kcl_pkg::CFG_DEFAULT_CODE, 16'h0000);
            write_reg(kcl_pkg::CFG_FAIL_LIMIT, 16'd15);
            write_reg(kcl_pkg::CFG_OPEN_SECONDS, 16'd255);
            write_reg(kcl_pkg::CFG_ALARM_SECONDS, 16'd255);
          end
          3: begin  // never locks, closes on first tick, unmatchable factory digits
            write_reg(kcl_pkg::CFG_DEFAULT_CODE, 16'hFA9F);
            write_reg(kcl_pkg::CFG_FAIL_LIMIT, 16'd0);
            write_reg(kcl_pkg::CFG_OPEN_SECONDS, 16'd0);
            write_reg(kcl_pkg::CFG_ALARM_SECONDS, 16'd8);
          end
          default: begin
            write_reg(kcl_pkg::CFG_DEFAULT_CODE, random_bcd());
            write_reg(kcl_pkg::CFG_FAIL_LIMIT, 16'($urandom_range(1, 5)));
            write_reg(kcl_pkg::CFG_OPEN_SECONDS, 16'($urandom_range(1, 10)));
            write_reg(kcl_pkg::CFG_ALARM_SECONDS, 16'($urandom_range(1, 12)));
          end
        endcase
        // Drop the write strobe after the last beat of the group
        cfg_valid <= 1'b0;
        // Pull the new factory code in so right-code sequences can use it
        if (chunk != 3 || $urandom_range(1) == 0) send_key(kcl_pkg::KEY_RESTORE);
      end

      case (chunk % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      // Hold the receiver off for a long stretch while beats keep coming
      if (chunk == 5) begin
        tx_idle_pct = 0;
        hold_asked++;
      end

      chunk_start = beats_in;
      while (beats_in - chunk_start < CHUNK_BEATS) run_sequence();
    end

    settle_idle();
    repeat (4) @(posedge clk);
    if (lock_views_due.size() != 0)
      note_mismatch("views never delivered", lock_views_due.size(), 0);

    $display("Run covered %0d input beats, %0d result beats checked, %0d register writes.",
             beats_in, beats_checked, cfg_writes);
    $display("Views with lock open: %0d, with alarm: %0d; input held off %0d cycles.",
             opens_seen, lockouts_seen, held_in_cycles);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1600000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
